>>> sv/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// lsbse_pkg
// shared types and constants for the lsb stego embedder
// ----------------------------------------------------------------------------
package lsbse_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUF_W    = 16;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned BPB_W    = 4;

  // most pending bits that still leave room for one more message byte
  localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'(BUF_W - BYTE_W);
  localparam logic [BPB_W-1:0] BPB_RESET  = BPB_W'(1);
  localparam logic [BPB_W-1:0] BPB_MAX    = BPB_W'(BYTE_W);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_COVER = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_LOADED   = 2'd0,
    ST_EMBEDDED = 2'd1,
    ST_PASSED   = 2'd2,
    ST_REFUSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] message_byte;
    logic              message_last;
    logic [BYTE_W-1:0] cover_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        status;
  } out_word_t;

  // handoff between the item register and the result register
  typedef struct packed {
    logic item_valid;
    logic advance;
  } link_t;

endpackage

>>> sv/lsbse_in_reg.sv
// ----------------------------------------------------------------------------
// lsbse_in_reg
// input item register with stall back to the input channel
// ----------------------------------------------------------------------------
module lsbse_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsbse_pkg::in_word_t in_data,
  input  logic               advance,
  output lsbse_pkg::link_t   link,
  output lsbse_pkg::in_word_t item
);

  logic                valid_r;
  logic                valid_nxt;
  lsbse_pkg::in_word_t item_r;
  logic                take;

  assign in_stall = valid_r & ~advance;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign link.item_valid = valid_r;
  assign link.advance    = advance;
  assign item            = item_r;

endmodule

>>> sv/lsbse_embed.sv
// ----------------------------------------------------------------------------
// lsbse_embed
// bit buffer state, bits-per-byte register and the embed logic
// ----------------------------------------------------------------------------
module lsbse_embed (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [lsbse_pkg::BPB_W-1:0] cfg_wr_data,
  input  lsbse_pkg::link_t    link,
  input  lsbse_pkg::in_word_t item,
  output lsbse_pkg::out_word_t result
);

  logic [lsbse_pkg::BPB_W-1:0]  bpb_r;
  logic [lsbse_pkg::BUF_W-1:0]  buf_r, buf_nxt;
  logic [lsbse_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         ended_r, ended_nxt;

  logic                         fire;
  logic [lsbse_pkg::BPB_W-1:0]  n;
  logic [lsbse_pkg::CNT_W-1:0]  n_ext;
  logic [lsbse_pkg::BYTE_W-1:0] nmask;
  logic [lsbse_pkg::CNT_W-1:0]  hi_sh;
  logic [lsbse_pkg::BPB_W-1:0]  lo_sh;
  logic [lsbse_pkg::BYTE_W-1:0] piece_hi;
  logic [lsbse_pkg::BYTE_W-1:0] piece_lo;
  logic [lsbse_pkg::BYTE_W-1:0] piece;
  logic [lsbse_pkg::BUF_W-1:0]  keep_mask;
  logic [lsbse_pkg::BUF_W-1:0]  live_mask;

  assign fire = link.item_valid & link.advance;

  // zero acts as one, anything above a byte acts as a full byte
  always_comb begin
    if (bpb_r == '0) begin
      n = lsbse_pkg::BPB_W'(1);
    end else if (bpb_r > lsbse_pkg::BPB_MAX) begin
      n = lsbse_pkg::BPB_MAX;
    end else begin
      n = bpb_r;
    end
  end

  assign n_ext    = lsbse_pkg::CNT_W'(n);
  assign nmask    = 8'hFF >> (lsbse_pkg::BPB_MAX - n);
  assign hi_sh    = cnt_r - n_ext;
  assign lo_sh    = n - cnt_r[lsbse_pkg::BPB_W-1:0];
  assign piece_hi = lsbse_pkg::BYTE_W'(buf_r >> hi_sh) & nmask;
  assign piece_lo = lsbse_pkg::BYTE_W'(buf_r << lo_sh) & nmask;
  // bits still pending after a full piece is taken
  assign keep_mask = ~({lsbse_pkg::BUF_W{1'b1}} << hi_sh);

  always_comb begin
    buf_nxt         = buf_r;
    cnt_nxt         = cnt_r;
    ended_nxt       = ended_r;
    piece           = '0;
    result.out_byte = '0;
    result.status   = lsbse_pkg::ST_LOADED;
    if (item.operation == lsbse_pkg::OP_LOAD) begin
      if (cnt_r > lsbse_pkg::LOAD_LIMIT) begin
        result.status = lsbse_pkg::ST_REFUSED;
      end else begin
        buf_nxt   = {buf_r[lsbse_pkg::BUF_W-lsbse_pkg::BYTE_W-1:0], item.message_byte};
        cnt_nxt   = cnt_r + lsbse_pkg::CNT_W'(lsbse_pkg::BYTE_W);
        ended_nxt = item.message_last;
      end
    end else begin
      priority if (cnt_r >= n_ext) begin
        piece   = piece_hi;
        cnt_nxt = hi_sh;
        buf_nxt = buf_r & keep_mask;
      end else if (cnt_r != '0 && ended_r) begin
        piece   = piece_lo;
        cnt_nxt = '0;
        buf_nxt = '0;
      end else begin
        result.out_byte = item.cover_byte;
        result.status   = lsbse_pkg::ST_PASSED;
      end
      if (result.status != lsbse_pkg::ST_PASSED) begin
        result.out_byte = (item.cover_byte & ~nmask) | piece;
        result.status   = lsbse_pkg::ST_EMBEDDED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpb_r   <= lsbse_pkg::BPB_RESET;
      buf_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bpb_r <= cfg_wr_data;
      end
      if (fire) begin
        buf_r   <= buf_nxt;
        cnt_r   <= cnt_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  // pending count never exceeds the buffer
  assign live_mask = ~({lsbse_pkg::BUF_W{1'b1}} << cnt_r);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lsbse_pkg::CNT_W'(lsbse_pkg::BUF_W))
    else $error("bit count beyond buffer");

  // bits above the pending count stay clear
  a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_r & ~live_mask) == '0)
    else $error("stale bits above bit count");

  // a refused load leaves the buffer state alone
  a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.operation == lsbse_pkg::OP_LOAD && cnt_r > lsbse_pkg::LOAD_LIMIT)
    |=> ($stable(cnt_r) && $stable(buf_r) && $stable(ended_r)))
    else $error("refused load changed state");

  // a pass-through consumes nothing
  a_pass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.status == lsbse_pkg::ST_PASSED) |=> $stable(cnt_r))
    else $error("pass-through consumed bits");

endmodule

>>> sv/lsbse_out_reg.sv
// ----------------------------------------------------------------------------
// lsbse_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
module lsbse_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  lsbse_pkg::out_word_t result,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsbse_pkg::out_word_t out_data
);

  logic                 valid_r;
  logic                 valid_nxt;
  lsbse_pkg::out_word_t data_r;
  logic                 load;

  assign advance = ~valid_r | ~out_stall;
  assign load    = item_valid & advance;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> sv/lsb_stego_embedder_core.sv
// ----------------------------------------------------------------------------
// lsb_stego_embedder_core
// hides message bits in the low bits of image color bytes
// ----------------------------------------------------------------------------
// Each input word either loads one message byte into a 16-bit bit buffer or
// presents one cover byte. A cover byte keeps its top 8-n bits and gets the
// next n message bits, msb first, in its low end (n from cfg_wr_data, 0 acts
// as 1 and values above 8 act as 8). After a byte flagged last, a final piece
// shorter than n is left-aligned with zero fill; with nothing to embed, cover
// bytes pass through. A load while more than 8 bits are pending is refused.
// Every input word gives exactly one result word. The block takes one word
// per clock while out_stall is low, moving it through an item register, then
// the embed logic feeding the result register. The buffer state is updated as
// the item moves into the result register, so back-to-back words see each
// other's effect with no bubble. A stalled result only blocks the input once
// the item register is also occupied. Write cfg only while the block is idle.
// ----------------------------------------------------------------------------
module lsb_stego_embedder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lsbse_pkg::BPB_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lsbse_pkg::in_word_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lsbse_pkg::out_word_t          out_data
);

  // handoff from item register to result register
  lsbse_pkg::link_t     link;
  lsbse_pkg::in_word_t  item;
  lsbse_pkg::out_word_t result;
  logic                 advance;

  // item register, holds one word while the result side is stalled
  lsbse_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .link     (link),
    .item     (item)
  );

  // bit buffer and embed logic, state moves only when the word advances
  lsbse_embed u_embed (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .link        (link),
    .item        (item),
    .result      (result)
  );

  // result register toward the output channel
  lsbse_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (link.item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
